[design/aac_pkg.sv]
// aac_pkg: shared types, sizes and codes of the axis auto-range calibrator
// used by the divider, the top and the checker; no dependencies
`default_nettype none

package aac_pkg;

  localparam int NUM_AXES     = 64;
  localparam int SAMPLE_WIDTH = 16;

  localparam int TYPE_W = 5;
  localparam int CODE_W = 9;
  localparam int CFG_W  = 16;
  localparam int AXIS_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  // divide: numerator is |out range| times offset, quotient never exceeds |out range|
  localparam int NUM_W  = CFG_W + SAMPLE_WIDTH;
  localparam int DIV_STEPS = CFG_W;
  localparam int CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int RES_W  = ((SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH : CFG_W) + 2;

  localparam logic [TYPE_W-1:0] EV_ABS = TYPE_W'(3);
  localparam logic [CODE_W-1:0] AXIS_LIMIT = CODE_W'(NUM_AXES);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = CFG_IDX_W'(1);

  localparam logic signed [CFG_W-1:0] OUT_MIN_RST = -CFG_W'(32768);
  localparam logic signed [CFG_W-1:0] OUT_MAX_RST = CFG_W'(32767);

  typedef struct packed {
    logic [TYPE_W-1:0]              event_type;
    logic [CODE_W-1:0]              event_code;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0]              out_type;
    logic [CODE_W-1:0]              out_code;
    logic signed [SAMPLE_WIDTH-1:0] out_value;
    logic                           was_scaled;
  } out_item_t;

  typedef struct packed {
    logic                           cal;
    logic signed [SAMPLE_WIDTH-1:0] low;
    logic signed [SAMPLE_WIDTH-1:0] high;
  } axis_entry_t;

  localparam int ENTRY_W = $bits(axis_entry_t);

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

endpackage

`default_nettype wire

[design/aac_ram.sv]
// aac_ram: generic single-write, single-read ram with registered read data
// no package dependency
`default_nettype none

module aac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/aac_div.sv]
// aac_div: restoring unsigned divider, one quotient bit per cycle
// depends on aac_pkg for operand widths and the start/done struct
`default_nettype none

module aac_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire aac_pkg::div_ctrl_t               ctrl_i,
  input  wire logic [aac_pkg::NUM_W-1:0]        dividend_i,
  input  wire logic [aac_pkg::SAMPLE_WIDTH-1:0] divisor_i,
  output aac_pkg::div_ctrl_t                    ctrl_o,
  output logic [aac_pkg::CFG_W-1:0]             quotient_o
);
  import aac_pkg::*;

  logic [SAMPLE_WIDTH-1:0] rem_q, rem_d;
  logic [CFG_W-1:0]        num_q, num_d;
  logic [SAMPLE_WIDTH-1:0] dsr_q;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    done_q, done_d;
  logic [SAMPLE_WIDTH:0]   trial;
  logic [SAMPLE_WIDTH:0]   diff;
  logic                    qbit;

  // quotient fits in CFG_W bits, so the upper dividend bits are already below the divisor
  assign trial = {rem_q, num_q[CFG_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign qbit  = !diff[SAMPLE_WIDTH];

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rem_d = dividend_i[NUM_W-1:CFG_W];
      num_d = dividend_i[CFG_W-1:0];
      cnt_d = CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      rem_d  = qbit ? diff[SAMPLE_WIDTH-1:0] : trial[SAMPLE_WIDTH-1:0];
      num_d  = {num_q[CFG_W-2:0], qbit};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    if (ctrl_i.start) begin
      dsr_q <= divisor_i;
    end
  end

  assign ctrl_o.start = 1'b0;
  assign ctrl_o.done  = done_q;
  assign quotient_o   = num_q;

endmodule

`default_nettype wire

[design/axis_autorange_calibrator.sv]
// axis_autorange_calibrator: per-axis min/max learning and linear rescale of abs events
// pass-through items go from accept to the done state; other axis items pass the read
// state first, a rescaled item also the multiply state and 16 divider steps; one item in
// flight, the next taken the cycle after the result loads, which waits out output stalls
// reset clears control, the per-axis valid bits and the output range to its full span
// depends on aac_pkg, aac_ram and aac_div
`default_nettype none

module axis_autorange_calibrator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire aac_pkg::in_item_t             in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output aac_pkg::out_item_t                 out_item_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [aac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [aac_pkg::CFG_W-1:0]     cfg_data_i
);
  import aac_pkg::*;

  ctrl_state_e state_q, state_d;

  in_item_t                 item_q;
  logic [NUM_AXES-1:0]      valid_q;
  logic [SAMPLE_WIDTH-1:0]  diff_q;
  logic [SAMPLE_WIDTH-1:0]  span_q;
  logic [SAMPLE_WIDTH-1:0]  result_q;
  logic                     scaled_q;
  logic                     out_valid_q;
  out_item_t                out_item_q;
  logic signed [CFG_W-1:0]  out_min_q;
  logic signed [CFG_W-1:0]  out_max_q;

  logic                     in_acc;
  logic                     is_axis;
  logic                     ram_we;
  logic                     load_out;
  logic [ENTRY_W-1:0]       ram_rdata;
  axis_entry_t              entry;
  axis_entry_t              entry_new;
  logic [AXIS_W-1:0]        axis_idx;

  logic signed [SAMPLE_WIDTH:0] span_w;
  logic signed [SAMPLE_WIDTH:0] diff_w;
  logic                         span_zero;

  logic signed [CFG_W:0]    range_w;
  logic                     range_neg;
  logic [CFG_W-1:0]         range_mag;
  logic [NUM_W-1:0]         product;
  div_ctrl_t                div_req;
  div_ctrl_t                div_rsp;
  logic [CFG_W-1:0]         quotient;
  logic signed [RES_W-1:0]  signed_q;
  logic signed [RES_W-1:0]  res_w;
  logic signed [RES_W-1:0]  min_w;

  assign in_acc   = in_valid_i && in_ready_o;
  assign is_axis  = (in_item_i.event_type == EV_ABS) && (in_item_i.event_code < AXIS_LIMIT);
  assign axis_idx = item_q.event_code[AXIS_W-1:0];

  // ---------------------------------------------------------------- state memory
  aac_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_AXES)
  ) u_axis_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (axis_idx),
    .wdata_i (entry_new),
    .re_i    (in_acc),
    .raddr_i (in_item_i.event_code[AXIS_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // an axis never written reads as all zero
  assign entry = valid_q[axis_idx] ? axis_entry_t'(ram_rdata) : '0;

  // read-modify-write of the axis entry; next item's read comes after the write
  always_comb begin
    entry_new = entry;
    if (!entry.cal) begin
      if (entry.low == '0) begin
        entry_new.low = item_q.sample_value;
      end else if (entry.low < item_q.sample_value) begin
        entry_new.high = item_q.sample_value;
        entry_new.cal  = 1'b1;
      end else if (entry.low > item_q.sample_value) begin
        entry_new.high = entry.low;
        entry_new.low  = item_q.sample_value;
        entry_new.cal  = 1'b1;
      end
    end else begin
      if (item_q.sample_value < entry.low) begin
        entry_new.low = item_q.sample_value;
      end
      if (item_q.sample_value > entry.high) begin
        entry_new.high = item_q.sample_value;
      end
    end
  end

  assign span_w    = (SAMPLE_WIDTH + 1)'(entry_new.high) - (SAMPLE_WIDTH + 1)'(entry_new.low);
  assign diff_w    = (SAMPLE_WIDTH + 1)'(item_q.sample_value) - (SAMPLE_WIDTH + 1)'(entry_new.low);
  assign span_zero = (span_w == '0);

  // ---------------------------------------------------------------- scale datapath
  assign range_w   = (CFG_W + 1)'(out_max_q) - (CFG_W + 1)'(out_min_q);
  assign range_neg = range_w[CFG_W];
  assign range_mag = range_neg ? CFG_W'(-range_w) : range_w[CFG_W-1:0];
  assign product   = range_mag * diff_q;

  assign div_req.start = (state_q == ST_MUL);
  assign div_req.done  = 1'b0;

  aac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_req),
    .dividend_i (product),
    .divisor_i  (span_q),
    .ctrl_o     (div_rsp),
    .quotient_o (quotient)
  );

  // sign-magnitude keeps truncation toward zero
  assign signed_q = range_neg ? -RES_W'(quotient) : RES_W'(quotient);
  assign min_w    = RES_W'(out_min_q);
  assign res_w    = min_w + signed_q;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = is_axis ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_d = (entry.cal && !span_zero) ? ST_MUL : ST_DONE;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_READ: ram_we     = 1'b1;
      ST_MUL:  ;
      ST_DIV:  ;
      ST_DONE: load_out   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      out_min_q   <= OUT_MIN_RST;
      out_max_q   <= OUT_MAX_RST;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        valid_q[axis_idx] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_OUT_MIN) begin
          out_min_q <= cfg_data_i;
        end else if (cfg_index_i == REG_OUT_MAX) begin
          out_max_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q   <= in_item_i;
      result_q <= in_item_i.sample_value;
      scaled_q <= 1'b0;
    end
    if (state_q == ST_READ) begin
      diff_q <= diff_w[SAMPLE_WIDTH-1:0];
      span_q <= span_w[SAMPLE_WIDTH-1:0];
      if (entry.cal) begin
        scaled_q <= 1'b1;
        if (span_zero) begin
          result_q <= min_w[SAMPLE_WIDTH-1:0];
        end
      end
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      result_q <= res_w[SAMPLE_WIDTH-1:0];
    end
    if (load_out) begin
      out_item_q.out_type   <= item_q.event_type;
      out_item_q.out_code   <= item_q.event_code;
      out_item_q.out_value  <= result_q;
      out_item_q.was_scaled <= scaled_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

[design/aac_checker.sv]
// aac_checker: port-level properties of the axis auto-range calibrator, bound to the top
// depends on aac_pkg and on the top level's port list
`default_nettype none

module aac_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire aac_pkg::in_item_t             in_item_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire aac_pkg::out_item_t            out_item_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [aac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input wire logic [aac_pkg::CFG_W-1:0]     cfg_data_i
);
  import aac_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // only in-range absolute-axis items can be rescaled
  a_scaled_abs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.was_scaled |->
      (out_item_o.out_type == EV_ABS) && (out_item_o.out_code < AXIS_LIMIT))
    else $error("scaled item that is not an absolute axis event");

  // one item at a time: ready drops after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  // no result appears the cycle right after an accept
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind axis_autorange_calibrator aac_checker u_aac_checker (.*);

`default_nettype wire
